// ===== src/combined_lcg_shuffle_rng_core_defines.svh =====
// Assertion helpers shared by the generator core.
`ifndef COMBINED_LCG_SHUFFLE_RNG_CORE_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_CORE_DEFINES_SVH

// Same-cycle implication.
`define CLSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/clsr_pkg.sv =====
package clsr_pkg;

	localparam int WORD_W          = 31;
	localparam int PROD_W          = 47;
	localparam int TABLE_DEPTH_DEF = 32;

	localparam logic [30:0] MOD_ONE       = 31'd2147483563;
	localparam logic [30:0] MOD_TWO       = 31'd2147483399;
	localparam logic [15:0] MUL_ONE       = 16'd40014;
	localparam logic [15:0] MUL_TWO       = 16'd40692;
	// 2^31 mod modulus, used to fold the product high part back in
	localparam logic [7:0]  FOLD_ONE      = 8'd85;
	localparam logic [7:0]  FOLD_TWO      = 8'd249;
	localparam logic [30:0] TOP_SPAN      = 31'd2147483562;
	localparam logic [30:0] CAP_LIMIT     = 31'd2147483306;
	localparam logic [30:0] GEN_TWO_RESET = 31'd123456789;

	typedef struct packed {
		logic seed_load;
		logic mul_go;
		logic commit_one;
		logic commit_two;
		logic seed_wr;
		logic load_last;
		logic div_init;
		logic div_back;
		logic div_fix;
		logic tbl_rd;
		logic draw_out;
	} cmd_t;

	// p mod m for p < 2^47 and m = 2^31 - k; one correction suffices
	function automatic logic [30:0] fold_mod(input logic [46:0] p, input logic [7:0] k,
			input logic [30:0] m);
		logic [31:0] s;
		s = 32'(p[30:0]) + 32'(p[46:31]) * 32'(k);
		if (s >= 32'(m)) begin
			s = s - 32'(m);
		end
		return s[30:0];
	endfunction

endpackage

// ===== src/clsr_ram.sv =====
module clsr_ram import clsr_pkg::*; #(
	parameter int WIDTH = WORD_W,
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/clsr_datapath.sv =====
module clsr_datapath import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	input  logic [$clog2(TABLE_DEPTH)-1:0] seed_addr,
	input  logic [30:0]                    seed_value,
	output logic [30:0]                    value,
	output logic                           at_top
);

	`include "combined_lcg_shuffle_rng_core_defines.svh"

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int EST_W  = ADDR_W + 1;
	localparam logic [31:0] SEL_DIV = 32'(1 + TOP_SPAN / TABLE_DEPTH);
	// floor(2^32 / SEL_DIV); the estimate is low by at most one
	localparam logic [8:0]  RECIP   = 9'((64'd1 << 32) / 64'(SEL_DIV));

	logic [30:0]            gen_one_q;
	logic [30:0]            gen_two_q;
	logic [30:0]            last_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                   vld_rd_q;
	logic [PROD_W-1:0]      prod1_s1;
	logic [PROD_W-1:0]      prod2_s1;
	logic [EST_W-1:0]       est_s1;
	logic [31:0]            thr_s2;
	logic [EST_W-1:0]       quo_q;
	logic [30:0]            value_q;
	logic                   at_top_q;

	logic [30:0]       seed_eff;
	logic [30:0]       fold1;
	logic [30:0]       fold2;
	logic [39:0]       est_prod;
	logic [ADDR_W-1:0] sel;
	logic [30:0]       rd_data;
	logic [30:0]       tword;
	logic [32:0]       diff;
	logic [32:0]       adj;
	logic [30:0]       res;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [30:0]       ram_wdata;

	assign seed_eff = (seed_value == 31'd0) ? 31'd1 : seed_value;
	assign fold1    = fold_mod(prod1_s1, FOLD_ONE, MOD_ONE);
	assign fold2    = fold_mod(prod2_s1, FOLD_TWO, MOD_TWO);
	assign est_prod = 40'(last_q) * 40'(RECIP);

	assign sel = (quo_q > EST_W'(TABLE_DEPTH - 1)) ?
		ADDR_W'(TABLE_DEPTH - 1) : quo_q[ADDR_W-1:0];

	assign ram_we    = cmd.seed_wr | cmd.draw_out;
	assign ram_waddr = cmd.draw_out ? sel : seed_addr;
	assign ram_wdata = cmd.draw_out ? gen_one_q : fold1;

	clsr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.tbl_rd),
		.raddr(sel),
		.rdata(rd_data)
	);

	// entries never written read as zero
	assign tword = vld_rd_q ? rd_data : 31'd0;
	assign diff  = {2'b00, tword} - {2'b00, gen_two_q};
	assign adj   = (diff[32] || diff == 33'd0) ? diff + 33'(TOP_SPAN) : diff;
	assign res   = adj[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_one_q <= 31'd1;
			gen_two_q <= GEN_TWO_RESET;
			last_q    <= 31'd0;
			vld_q     <= '0;
		end else begin
			if (cmd.seed_load) begin
				gen_one_q <= seed_eff;
				gen_two_q <= seed_eff;
			end
			if (cmd.commit_one) begin
				gen_one_q <= fold1;
			end
			if (cmd.commit_two) begin
				gen_two_q <= fold2;
			end
			if (cmd.load_last) begin
				last_q <= fold1;
			end
			if (cmd.seed_wr) begin
				vld_q[seed_addr] <= 1'b1;
			end
			if (cmd.draw_out) begin
				vld_q[sel] <= 1'b1;
				last_q     <= res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod1_s1 <= PROD_W'(gen_one_q) * PROD_W'(MUL_ONE);
			prod2_s1 <= PROD_W'(gen_two_q) * PROD_W'(MUL_TWO);
		end
		if (cmd.div_init) begin
			est_s1 <= est_prod[32 +: EST_W];
		end
		if (cmd.div_back) begin
			thr_s2 <= (32'(est_s1) + 32'd1) * SEL_DIV;
		end
		if (cmd.div_fix) begin
			quo_q <= ({1'b0, last_q} >= thr_s2) ? est_s1 + EST_W'(1) : est_s1;
		end
		if (cmd.tbl_rd) begin
			vld_rd_q <= vld_q[sel];
		end
		if (cmd.draw_out) begin
			value_q  <= res;
			at_top_q <= (res >= CAP_LIMIT);
		end
	end

	assign value  = value_q;
	assign at_top = at_top_q;

	`CLSR_ASSERT_NEXT(a_gen_one_range, clk, arst_n, cmd.commit_one, gen_one_q < MOD_ONE,
		"first generator left its range")
	`CLSR_ASSERT_NEXT(a_gen_two_range, clk, arst_n, cmd.commit_two, gen_two_q < MOD_TWO,
		"second generator left its range")
	`CLSR_ASSERT_NEXT(a_value_range, clk, arst_n, cmd.draw_out,
		(value_q != 31'd0) && (value_q <= TOP_SPAN), "output value out of range")

endmodule

// ===== src/clsr_ctrl.sv =====
module clsr_ctrl import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           func,
	output logic                           s_axis_tready,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output cmd_t                           cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0] seed_addr
);

	`include "combined_lcg_shuffle_rng_core_defines.svh"

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_SEED_MUL = 8'b0000_0010,
		ST_SEED_RED = 8'b0000_0100,
		ST_DRAW_MUL = 8'b0000_1000,
		ST_DRAW_RED = 8'b0001_0000,
		ST_DRAW_DIV = 8'b0010_0000,
		ST_DRAW_RD  = 8'b0100_0000,
		ST_DRAW_OUT = 8'b1000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             m_valid_q;
	logic             accept;
	logic             out_free;

	assign accept   = (state_q == ST_IDLE) && s_axis_tvalid;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func) begin
						state_d = ST_SEED_MUL;
						cnt_d   = CNT_W'(TABLE_DEPTH + 7);
					end else begin
						state_d = ST_DRAW_MUL;
					end
				end
			end
			ST_SEED_MUL: begin
				state_d = ST_SEED_RED;
			end
			ST_SEED_RED: begin
				if (cnt_q == '0) begin
					state_d = ST_DRAW_MUL;
				end else begin
					state_d = ST_SEED_MUL;
					cnt_d   = cnt_q - 1'b1;
				end
			end
			ST_DRAW_MUL: begin
				state_d = ST_DRAW_RED;
			end
			ST_DRAW_RED: begin
				state_d = ST_DRAW_DIV;
			end
			ST_DRAW_DIV: begin
				state_d = ST_DRAW_RD;
			end
			ST_DRAW_RD: begin
				state_d = ST_DRAW_OUT;
			end
			ST_DRAW_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.seed_load  = accept && func;
		cmd.mul_go     = (state_q == ST_SEED_MUL) || (state_q == ST_DRAW_MUL);
		cmd.commit_one = (state_q == ST_SEED_RED) || (state_q == ST_DRAW_RED);
		cmd.commit_two = (state_q == ST_DRAW_RED);
		cmd.seed_wr    = (state_q == ST_SEED_RED) && (cnt_q < CNT_W'(TABLE_DEPTH));
		cmd.load_last  = (state_q == ST_SEED_RED) && (cnt_q == '0);
		cmd.div_init   = (state_q == ST_DRAW_MUL);
		cmd.div_back   = (state_q == ST_DRAW_RED);
		cmd.div_fix    = (state_q == ST_DRAW_DIV);
		cmd.tbl_rd     = (state_q == ST_DRAW_RD);
		cmd.draw_out   = (state_q == ST_DRAW_OUT) && out_free;
	end

	assign seed_addr = cnt_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.draw_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;

	`CLSR_ASSERT_NOW(a_out_source, clk, arst_n, $rose(m_valid_q), $past(cmd.draw_out),
		"output valid rose without a finished draw")

endmodule

// ===== src/combined_lcg_shuffle_rng_core.sv =====
// Combined two-generator multiplicative RNG with a shuffle table. Each input item
// (tuser = func, tdata = seed) yields exactly one output item: tdata = value in
// 1..2147483562, tuser = at_top. func = 0 draws the next number; func = 1 reseeds
// both generators from the seed (zero taken as one), runs TABLE_DEPTH + 8 steps of
// the first generator to fill the table, then draws. A draw occupies the core from
// accept to the next possible accept with these steps: a multiply and a fold step
// for the generators, a step to settle the table index (formed from the previous
// output by a reciprocal multiply with one correction), the registered table read,
// the output write, and the idle state that takes the next item; a busy receiver
// stalls the output write. A reseed adds a multiply state and a fold state per step
// of the generator loop. The output register holds a finished item while the next
// input is taken. The table needs no clearing pass after reset: never-written
// entries read as zero.
module combined_lcg_shuffle_rng_core import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] seed_value
	input  logic [0:0]  s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [30:0] value
	output logic [0:0]  m_axis_tuser    // [0] at_top
);

	cmd_t                           cmd;
	logic [$clog2(TABLE_DEPTH)-1:0] seed_addr;
	logic [30:0]                    value;
	logic                           at_top;

	clsr_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.func         (s_axis_tuser[0]),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cmd          (cmd),
		.seed_addr    (seed_addr)
	);

	clsr_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.seed_addr (seed_addr),
		.seed_value(s_axis_tdata[30:0]),
		.value     (value),
		.at_top    (at_top)
	);

	assign m_axis_tdata = {1'b0, value};
	assign m_axis_tuser = at_top;

endmodule
